// ===== rtl/core/d2q9_bgk_collision_top_defines.svh =====
// Assertion macros for the D2Q9 BGK collision block.
// Expects clk and arst_n in the scope where a macro is used.
`ifndef D2Q9_BGK_COLLISION_TOP_DEFINES_SVH
`define D2Q9_BGK_COLLISION_TOP_DEFINES_SVH

// same-cycle implication, disabled during reset
`define D2Q9_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define D2Q9_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/d2q9_pkg.sv =====
// Types, constants and helper functions for the D2Q9 BGK collision block.
// No dependencies; used by the interfaces, the lane, the top level and the checker.
package d2q9_pkg;

	localparam int Q_FRAC = 24;
	localparam int NDIR = 9;
	localparam int NSTG = 9;
	localparam int CFG_IDX_W = 4;
	localparam int CFG_DATA_W = 32;
	localparam int RATE_W = 26;
	localparam int USQ_W = 41;
	localparam int Y_W = 35;
	localparam int RECIP_W = 36;
	localparam int RECIP_SHIFT = 39;

	typedef logic signed [31:0] q824_t;
	typedef logic [RATE_W-1:0] rate_t;
	typedef logic signed [USQ_W-1:0] usq_t;
	typedef q824_t dvec_t [NDIR];

	typedef struct packed {
		q824_t density;
		q824_t vel_x;
		q824_t vel_y;
		q824_t dist_0;
		q824_t dist_1;
		q824_t dist_2;
		q824_t dist_3;
		q824_t dist_4;
		q824_t dist_5;
		q824_t dist_6;
		q824_t dist_7;
		q824_t dist_8;
	} cell_t;

	typedef struct packed {
		q824_t post_0;
		q824_t post_1;
		q824_t post_2;
		q824_t post_3;
		q824_t post_4;
		q824_t post_5;
		q824_t post_6;
		q824_t post_7;
		q824_t post_8;
	} post_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_RELAX_RATE = 4'd0,
		REG_EQ_MODE    = 4'd1
	} cfg_reg_t;

	typedef enum logic {
		EQ_FLUID   = 1'b0,
		EQ_THERMAL = 1'b1
	} eq_mode_t;

	typedef enum logic [1:0] {
		WT_4_9,
		WT_1_9,
		WT_1_36
	} wt_t;

	// per-lane stage enables plus the configuration the lanes read
	typedef struct packed {
		logic [NSTG-1:0] en;
		rate_t           relax_rate;
		eq_mode_t        eq_mode;
	} ctl_t;

	localparam rate_t RELAX_RESET = 26'd16777216;
	localparam logic signed [63:0] RND_Q24 = 64'sd8388608;
	localparam logic [RECIP_W-1:0] RECIP9 = 36'd61083979321;
	// 9 * (2^31 + 1): any quotient at or above this saturates either way
	localparam logic [Y_W-1:0] Y_CLAMP = 35'd19327352841;

	localparam logic signed [1:0] DIR_X [NDIR] =
		'{2'sd0, 2'sd1, 2'sd0, -2'sd1, 2'sd0, 2'sd1, -2'sd1, -2'sd1, 2'sd1};
	localparam logic signed [1:0] DIR_Y [NDIR] =
		'{2'sd0, 2'sd0, 2'sd1, 2'sd0, -2'sd1, 2'sd1, 2'sd1, -2'sd1, -2'sd1};
	localparam wt_t LANE_WT [NDIR] =
		'{WT_4_9, WT_1_9, WT_1_9, WT_1_9, WT_1_9, WT_1_36, WT_1_36, WT_1_36, WT_1_36};

	function automatic q824_t sat32(input logic signed [63:0] x);
		q824_t r;
		if (x > 64'sd2147483647) begin
			r = 32'sh7fffffff;
		end else if (x < -64'sd2147483648) begin
			r = 32'sh80000000;
		end else begin
			r = x[31:0];
		end
		return r;
	endfunction

	// t = cx*ux + cy*uy, saturated
	function automatic q824_t proj(input logic signed [1:0] cx, input logic signed [1:0] cy,
			input q824_t ux, input q824_t uy);
		logic signed [33:0] sx;
		logic signed [33:0] sy;
		sx = (cx == 2'sd0) ? 34'sd0 : ((cx == 2'sd1) ? 34'(ux) : -34'(ux));
		sy = (cy == 2'sd0) ? 34'sd0 : ((cy == 2'sd1) ? 34'(uy) : -34'(uy));
		return sat32(64'(sx + sy));
	endfunction

	function automatic dvec_t to_dvec(input cell_t c);
		dvec_t v;
		v[0] = c.dist_0;
		v[1] = c.dist_1;
		v[2] = c.dist_2;
		v[3] = c.dist_3;
		v[4] = c.dist_4;
		v[5] = c.dist_5;
		v[6] = c.dist_6;
		v[7] = c.dist_7;
		v[8] = c.dist_8;
		return v;
	endfunction

	function automatic post_t to_post(input dvec_t v);
		post_t p;
		p.post_0 = v[0];
		p.post_1 = v[1];
		p.post_2 = v[2];
		p.post_3 = v[3];
		p.post_4 = v[4];
		p.post_5 = v[5];
		p.post_6 = v[6];
		p.post_7 = v[7];
		p.post_8 = v[8];
		return p;
	endfunction

endpackage

// ===== rtl/core/d2q9_if.sv =====
// Channel interfaces for the D2Q9 BGK collision block: a valid/ready stream
// carrying a typed payload, and the register write channel. Uses d2q9_pkg.
interface d2q9_stream_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface d2q9_cfg_if;
	import d2q9_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/d2q9_lane.sv =====
// One direction of the collision: equilibrium, weighting and relaxation
// over nine register stages. Uses d2q9_pkg; instantiated by the top level.
module d2q9_lane (
	input  logic             clk,
	input  d2q9_pkg::ctl_t   ctl,
	input  d2q9_pkg::wt_t    wt,
	input  d2q9_pkg::q824_t  t_in,
	input  d2q9_pkg::q824_t  f_in,
	input  d2q9_pkg::usq_t   usq_s2,
	input  d2q9_pkg::q824_t  rho_s3,
	output d2q9_pkg::q824_t  post_s9
);
	import d2q9_pkg::*;

	q824_t              t_s1, t_s2;
	q824_t              f_s1, f_s2, f_s3, f_s4, f_s5, f_s6, f_s7, f_s8;
	logic signed [63:0] tt_s2;
	q824_t              poly_s3;
	logic signed [63:0] prod_s4;
	logic [Y_W-1:0]     y_s5;
	logic               neg_s5, neg_s6;
	logic [35:0]        pp_ll_s6, pp_lh_s6, pp_hl_s6, pp_hh_s6;
	q824_t              feq_s7;
	logic signed [59:0] rp_s8;

	logic signed [39:0] tsq_c;
	logic signed [45:0] p2_c;
	logic signed [39:0] g_c;
	logic [39:0]        mag_c;
	logic [41:0]        yraw_c;
	logic [Y_W-1:0]     y_c;
	logic [71:0]        sum_c;
	logic [32:0]        q_c;
	logic signed [63:0] qs_c;
	logic signed [26:0] om_c;
	logic signed [32:0] d_c;
	logic signed [63:0] r_c;

	// stage 1: projection and distribution in
	always_ff @(posedge clk) begin
		if (ctl.en[0]) begin
			t_s1 <= t_in;
			f_s1 <= f_in;
		end
	end

	// stage 2: t squared
	always_ff @(posedge clk) begin
		if (ctl.en[1]) begin
			tt_s2 <= 64'(t_s1) * 64'(t_s1);
			t_s2  <= t_s1;
			f_s2  <= f_s1;
		end
	end

	// stage 3: polynomial, Q.25 then halved
	always_comb begin
		tsq_c = 40'((tt_s2 + RND_Q24) >>> Q_FRAC);
		p2_c  = 46'sd33554432 + 46'(t_s2) * 46'sd6;
		if (ctl.eq_mode == EQ_FLUID) begin
			p2_c = p2_c + 46'(tsq_c) * 46'sd9 - 46'(usq_s2) * 46'sd3;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en[2]) begin
			poly_s3 <= sat32(64'((p2_c + 46'sd1) >>> 1));
			f_s3    <= f_s2;
		end
	end

	// stage 4: rho * poly
	always_ff @(posedge clk) begin
		if (ctl.en[3]) begin
			prod_s4 <= 64'(rho_s3) * 64'(poly_s3);
			f_s4    <= f_s3;
		end
	end

	// stage 5: magnitude, rounding offset and divisor folded to a divide by nine
	always_comb begin
		g_c   = 40'((prod_s4 + RND_Q24) >>> Q_FRAC);
		mag_c = g_c[39] ? 40'(-g_c) : 40'(g_c);
		unique case (wt)
			WT_4_9:  yraw_c = {mag_c, 2'b00} + 42'd4;
			WT_1_9:  yraw_c = 42'(mag_c) + 42'd4;
			WT_1_36: yraw_c = (42'(mag_c) + 42'd18) >> 2;
			default: yraw_c = '0;
		endcase
		y_c = (yraw_c >= 42'(Y_CLAMP)) ? Y_CLAMP : yraw_c[Y_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (ctl.en[4]) begin
			y_s5   <= y_c;
			neg_s5 <= g_c[39];
			f_s5   <= f_s4;
		end
	end

	// stage 6: reciprocal multiply, four partial products
	always_ff @(posedge clk) begin
		if (ctl.en[5]) begin
			pp_ll_s6 <= 36'(y_s5[17:0]) * 36'(RECIP9[17:0]);
			pp_lh_s6 <= 36'(y_s5[17:0]) * 36'(RECIP9[35:18]);
			pp_hl_s6 <= 36'(y_s5[34:18]) * 36'(RECIP9[17:0]);
			pp_hh_s6 <= 36'(y_s5[34:18]) * 36'(RECIP9[35:18]);
			neg_s6   <= neg_s5;
			f_s6     <= f_s5;
		end
	end

	// stage 7: quotient, sign back on, saturate
	always_comb begin
		sum_c = (72'(pp_hh_s6) << 36) + ((72'(pp_lh_s6) + 72'(pp_hl_s6)) << 18)
			+ 72'(pp_ll_s6);
		q_c   = sum_c[71:RECIP_SHIFT];
		qs_c  = neg_s6 ? -64'(q_c) : 64'(q_c);
	end

	always_ff @(posedge clk) begin
		if (ctl.en[6]) begin
			feq_s7 <= sat32(qs_c);
			f_s7   <= f_s6;
		end
	end

	// stage 8: omega * (feq - f)
	always_comb begin
		om_c = {1'b0, ctl.relax_rate};
		d_c  = 33'(feq_s7) - 33'(f_s7);
	end

	always_ff @(posedge clk) begin
		if (ctl.en[7]) begin
			rp_s8 <= 60'(om_c) * 60'(d_c);
			f_s8  <= f_s7;
		end
	end

	// stage 9: add back and saturate
	assign r_c = 64'(f_s8) + ((64'(rp_s8) + RND_Q24) >>> Q_FRAC);

	always_ff @(posedge clk) begin
		if (ctl.en[8]) begin
			post_s9 <= sat32(r_c);
		end
	end

endmodule

// ===== rtl/core/d2q9_bgk_collision_top.sv =====
// D2Q9 BGK collision, top level: pipeline control, shared velocity terms,
// configuration registers and nine direction lanes. Uses d2q9_pkg, d2q9_if, d2q9_lane.
//
//   channel  dir  handshake      payload
//   site     in   valid/ready    density, vel_x, vel_y, dist_0..dist_8 (cell_t)
//   post     out  valid/ready    post_0..post_8 (post_t)
//   cfg      in   valid/ready    index, data (0 relax_rate, 1 eq_mode)
//
// One cell per cycle unless post stalls; nine register stages from request to
// result, the last being the output register. Stages fill bubbles independently,
// so new requests are taken while a result waits as long as some stage is empty.
// Reset clears the stage valid bits and loads relax_rate 1.0, eq_mode fluid.
// cfg is always ready.
module d2q9_bgk_collision_top (
	input logic      clk,
	input logic      arst_n,
	d2q9_stream_if.sink   site,
	d2q9_stream_if.source post,
	d2q9_cfg_if.sink      cfg
);
	import d2q9_pkg::*;

	rate_t              relax_rate_q;
	eq_mode_t           eq_mode_q;
	logic [NSTG-1:0]    vld_q;
	logic [NSTG-1:0]    en_c;
	ctl_t               ctl_c;

	logic signed [63:0] uxx_s1, uyy_s1;
	q824_t              rho_s1, rho_s2, rho_s3;
	usq_t               usq_s2;
	usq_t               usq_c;

	cell_t              cell_c;
	dvec_t              dist_c;
	dvec_t              post_c;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			relax_rate_q <= RELAX_RESET;
			eq_mode_q    <= EQ_FLUID;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				REG_RELAX_RATE: relax_rate_q <= cfg.data[RATE_W-1:0];
				REG_EQ_MODE:    eq_mode_q    <= eq_mode_t'(cfg.data[0]);
				default: ;
			endcase
		end
	end

	assign cfg.ready = 1'b1;

	// a stage loads when it is empty or its content moves on
	always_comb begin
		en_c[NSTG-1] = !vld_q[NSTG-1] || post.ready;
		for (int i = NSTG - 2; i >= 0; i--) begin
			en_c[i] = !vld_q[i] || en_c[i+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en_c[0]) begin
				vld_q[0] <= site.valid;
			end
			for (int i = 1; i < NSTG; i++) begin
				if (en_c[i]) begin
					vld_q[i] <= vld_q[i-1];
				end
			end
		end
	end

	assign site.ready = en_c[0];
	assign post.valid = vld_q[NSTG-1];

	assign ctl_c.en         = en_c;
	assign ctl_c.relax_rate = relax_rate_q;
	assign ctl_c.eq_mode    = eq_mode_q;

	// shared terms: |u|^2 and the density, delayed to meet the lanes
	assign cell_c = site.data;
	assign dist_c = to_dvec(cell_c);
	assign usq_c  = USQ_W'((uxx_s1 + RND_Q24) >>> Q_FRAC)
		+ USQ_W'((uyy_s1 + RND_Q24) >>> Q_FRAC);

	always_ff @(posedge clk) begin
		if (en_c[0]) begin
			uxx_s1 <= 64'(cell_c.vel_x) * 64'(cell_c.vel_x);
			uyy_s1 <= 64'(cell_c.vel_y) * 64'(cell_c.vel_y);
			rho_s1 <= cell_c.density;
		end
		if (en_c[1]) begin
			usq_s2 <= usq_c;
			rho_s2 <= rho_s1;
		end
		if (en_c[2]) begin
			rho_s3 <= rho_s2;
		end
	end

	for (genvar k = 0; k < NDIR; k++) begin : g_lane
		d2q9_lane u_lane (
			.clk     (clk),
			.ctl     (ctl_c),
			.wt      (LANE_WT[k]),
			.t_in    (proj(DIR_X[k], DIR_Y[k], cell_c.vel_x, cell_c.vel_y)),
			.f_in    (dist_c[k]),
			.usq_s2  (usq_s2),
			.rho_s3  (rho_s3),
			.post_s9 (post_c[k])
		);
	end

	assign post.data = to_post(post_c);

endmodule

// ===== rtl/core/d2q9_chk.sv =====
// Port-level checker for the D2Q9 BGK collision top, bound in below.
// Uses d2q9_pkg and the macros in d2q9_bgk_collision_top_defines.svh.
`include "d2q9_bgk_collision_top_defines.svh"

module d2q9_chk (
	input logic            clk,
	input logic            arst_n,
	input logic            cell_valid,
	input logic            cell_ready,
	input logic            post_valid,
	input logic            post_ready,
	input d2q9_pkg::post_t post_data
);

	// a stalled result stays offered and unchanged
	`D2Q9_ASSERT_NEXT(a_post_hold, post_valid && !post_ready, post_valid, "result dropped while stalled")
	`D2Q9_ASSERT_NEXT(a_post_stable, post_valid && !post_ready, $stable(post_data), "stalled result changed")

	// a free output stage frees every stage behind it
	`D2Q9_ASSERT_IMPL(a_ready_free, !post_valid || post_ready, cell_ready, "request refused with output free")

	// a taken request's result is offered on time while the sink keeps taking
	`D2Q9_ASSERT_NEXT(a_latency, cell_valid && cell_ready ##1 post_ready ##1 post_ready ##1 post_ready ##1 post_ready ##1 post_ready ##1 post_ready ##1 post_ready ##1 post_ready, post_valid, "result late")

endmodule

bind d2q9_bgk_collision_top d2q9_chk u_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.cell_valid (site.valid),
	.cell_ready (site.ready),
	.post_valid (post.valid),
	.post_ready (post.ready),
	.post_data  (post.data)
);
